// ----- design/rbc_pkg.sv -----
package rbc_pkg;

  // Fixed field widths
  localparam int NUM_W   = 31;
  localparam int BASE_W  = 6;
  localparam int CHAR_W  = 7;
  localparam int PLAIN_W = 56;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register indexes (paddr[2])
  localparam logic REG_SOURCE_BASE = 1'b0;
  localparam logic REG_TARGET_BASE = 1'b1;

  localparam logic [BASE_W-1:0] BASE_RESET  = BASE_W'(10);
  localparam logic [BASE_W-1:0] MIN_TARGET  = BASE_W'(2);
  localparam logic [BASE_W-1:0] DEC_RADIX   = BASE_W'(10);

  // n / 10 == (n * RECIP_TEN) >> RECIP_SHIFT for any 32-bit n
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] ASCII_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ALPHA_OFFSET = CHAR_W'(7);

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Digit value to its ASCII symbol; symbols continue past 'Z' for large bases
  function automatic logic [CHAR_W-1:0] symbol_of(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] s;
    s = CHAR_W'(d) + ASCII_ZERO;
    if (d > BASE_W'(9)) begin
      s = s + ALPHA_OFFSET;
    end
    return s;
  endfunction

endpackage

// ----- design/rbc_divider.sv -----
module rbc_divider
  import rbc_pkg::*;
#(
  parameter int WIDTH = 56
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WIDTH-1:0]  dividend,
  input  logic [BASE_W-1:0] divisor,
  output logic [WIDTH-1:0]  quotient,
  output logic [BASE_W-1:0] remainder,
  output div_status_t       status
);

  localparam int SW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]  quo;
  logic [BASE_W-1:0] rem;
  logic [BASE_W-1:0] dvs;
  logic [SW-1:0]     steps;
  logic              busy;
  logic              done;

  logic [BASE_W:0] partial;
  logic [BASE_W:0] diff;
  logic            fits;

  // One restoring step per cycle, MSB first
  always_comb begin
    partial = {rem, quo[WIDTH-1]};
    diff    = partial - {1'b0, dvs};
    fits    = (partial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
        steps <= SW'(WIDTH);
        busy  <= 1'b1;
      end else if (busy) begin
        quo   <= {quo[WIDTH-2:0], fits};
        rem   <= fits ? diff[BASE_W-1:0] : partial[BASE_W-1:0];
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quo;
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  a_rem_below: assert property (@(posedge clk) disable iff (rst) done |-> (rem < dvs))
    else $error("remainder not below divisor");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_steps_live: assert property (@(posedge clk) disable iff (rst) busy |-> (steps != '0))
    else $error("busy with no steps left");

endmodule

// ----- design/rbc_digit_mem.sv -----
module rbc_digit_mem
  import rbc_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [BASE_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [BASE_W-1:0]        rd_data
);

  logic [BASE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/radix_base_converter.sv -----
// Channel   Direction  Handshake                   Word
// number    in         number_valid / number_stall number_in
// digit     out        digit_valid / digit_stall   digit_char, last_digit, plain_value
// apb       in/out     psel, penable, pready       source_base @0x0, target_base @0x4
//
// Decimal split by reciprocal multiply, a test and an accumulate state per decimal digit;
// the bit-serial divider makes each target digit.
// A word goes through the decimal split, then one divider run per target digit;
// each output digit adds a memory read, a load and a show.
// number_stall stays high from accept until the last digit word is taken.
// Output stalls hold the current digit word; rst is synchronous, bases reset to 10.
module radix_base_converter
  import rbc_pkg::*;
#(
  parameter int MAX_DIGITS  = 64,
  parameter int VALUE_WIDTH = 56
) (
  input  logic               clk,
  input  logic               rst,
  // input words
  input  logic               number_valid,
  output logic               number_stall,
  input  logic [NUM_W-1:0]   number_in,
  // output words
  output logic               digit_valid,
  input  logic               digit_stall,
  output logic [CHAR_W-1:0]  digit_char,
  output logic               last_digit,
  output logic [PLAIN_W-1:0] plain_value,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [3:0] {
    IDLE,
    DEC_TEST,
    DEC_ACC,
    CONV_START,
    CONV_DIV,
    OUT_RD,
    OUT_LOAD,
    OUT_SHOW
  } state_t;

  state_t state;

  logic [BASE_W-1:0]      source_base;
  logic [BASE_W-1:0]      target_base;
  logic [NUM_W-1:0]       num;
  logic [3:0]             dec_rem;
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] weight;
  logic [VALUE_WIDTH-1:0] plain;
  logic [VALUE_WIDTH-1:0] remaining_value;
  logic [CW-1:0]          digit_count;
  logic [AW-1:0]          rd_idx;

  logic                   cfg_wr;
  logic                   num_big;
  logic [BASE_W-1:0]      eff_target;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [BASE_W-1:0]      div_divisor;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [BASE_W-1:0]      div_rem;
  div_status_t            div_status;

  logic [NUM_W+31:0]      recip_prod;
  logic [NUM_W-1:0]       dec_q_now;
  logic [NUM_W-1:0]       dec_q_ten;
  logic [3:0]             dec_r_now;

  logic [3:0]             mul_digit;
  logic [VALUE_WIDTH+3:0] acc_prod;
  logic [VALUE_WIDTH+5:0] weight_prod;
  logic [VALUE_WIDTH-1:0] acc_sum;

  logic                   wr_en;
  logic [CW-1:0]          cnt_inc;
  logic                   rd_en;
  logic [BASE_W-1:0]      rd_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_SOURCE_BASE: prdata = DATA_W'(source_base);
      REG_TARGET_BASE: prdata = DATA_W'(target_base);
      default:         prdata = '0;
    endcase
  end

  assign number_stall = (state != IDLE);
  assign plain_value  = plain[PLAIN_W-1:0];

  assign num_big    = (num >= NUM_W'(DEC_RADIX));
  assign eff_target = (target_base < MIN_TARGET) ? MIN_TARGET : target_base;

  // Decimal split: quotient by reciprocal multiply, remainder by shift-add back
  always_comb begin
    recip_prod = num * RECIP_TEN;
    dec_q_now  = NUM_W'(recip_prod >> RECIP_SHIFT);
    dec_q_ten  = (dec_q_now << 3) + (dec_q_now << 1);
    dec_r_now  = 4'(num - dec_q_ten);
  end

  // Divider serves the target-base conversion
  assign div_start    = (state == CONV_START);
  assign div_dividend = remaining_value;
  assign div_divisor  = eff_target;

  always_comb begin
    mul_digit   = (state == DEC_TEST) ? num[3:0] : dec_rem;
    acc_prod    = mul_digit * weight;
    weight_prod = weight * source_base;
    acc_sum     = acc + acc_prod[VALUE_WIDTH-1:0];
  end

  // Digits past MAX_DIGITS are dropped; the low ones are kept
  assign wr_en   = (state == CONV_DIV) && div_status.done && (digit_count < CW'(MAX_DIGITS));
  assign cnt_inc = wr_en ? (digit_count + CW'(1)) : digit_count;
  assign rd_en   = (state == OUT_RD);

  rbc_divider #(
    .WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .status    (div_status)
  );

  rbc_digit_mem #(
    .DEPTH(MAX_DIGITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (digit_count[AW-1:0]),
    .wr_data (div_rem),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      source_base     <= BASE_RESET;
      target_base     <= BASE_RESET;
      remaining_value <= '0;
      digit_count     <= '0;
      digit_valid     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_SOURCE_BASE: source_base <= pwdata[BASE_W-1:0];
          REG_TARGET_BASE: target_base <= pwdata[BASE_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        IDLE: begin
          if (number_valid) begin
            num         <= number_in;
            acc         <= '0;
            weight      <= VALUE_WIDTH'(1);
            digit_count <= '0;
            state       <= DEC_TEST;
          end
        end
        DEC_TEST: begin
          if (num_big) begin
            num     <= dec_q_now;
            dec_rem <= dec_r_now;
            state   <= DEC_ACC;
          end else begin
            // top decimal digit closes the sum
            plain           <= acc_sum;
            remaining_value <= acc_sum;
            state           <= CONV_START;
          end
        end
        DEC_ACC: begin
          acc    <= acc_sum;
          weight <= weight_prod[VALUE_WIDTH-1:0];
          state  <= DEC_TEST;
        end
        CONV_START: begin
          state <= CONV_DIV;
        end
        CONV_DIV: begin
          if (div_status.done) begin
            digit_count <= cnt_inc;
            rd_idx      <= AW'(cnt_inc - CW'(1));
            if (div_quo == '0) begin
              state <= OUT_RD;
            end else begin
              remaining_value <= div_quo;
              state           <= CONV_START;
            end
          end
        end
        OUT_RD: begin
          state <= OUT_LOAD;
        end
        OUT_LOAD: begin
          digit_char  <= symbol_of(rd_data);
          last_digit  <= (rd_idx == '0);
          digit_valid <= 1'b1;
          state       <= OUT_SHOW;
        end
        OUT_SHOW: begin
          if (!digit_stall) begin
            digit_valid <= 1'b0;
            if (rd_idx == '0) begin
              state <= IDLE;
            end else begin
              rd_idx <= rd_idx - AW'(1);
              state  <= OUT_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_no_early_word: assert property (@(posedge clk) disable iff (rst)
      (number_valid && !number_stall) |=> !digit_valid)
    else $error("digit word right after accept");
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
      (digit_valid && !digit_stall && last_digit) |=> !number_stall)
    else $error("not ready after last digit");
  a_more_digits: assert property (@(posedge clk) disable iff (rst)
      (digit_valid && !digit_stall && !last_digit) |=> number_stall)
    else $error("ready before last digit");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
      digit_count <= CW'(MAX_DIGITS))
    else $error("digit count past store depth");

endmodule
